FILE: hw/rtl/rbrs_pkg.sv
package rbrs_pkg;

    localparam int SMP_W         = 16;
    localparam int PV_W          = 16;
    localparam int BLEN_W        = 7;
    localparam int MAX_BLOCK_DEF = 64;

    localparam logic [BLEN_W-1:0] BLEN_RST = 7'd8;

    localparam logic signed [PV_W-1:0] PV_MAX = 16'sh7FFF;
    localparam logic signed [PV_W-1:0] PV_MIN = 16'sh8000;

    // sum of squares width: one square needs 31 bits (2**30 at most)
    function automatic int sq_w(input int max_block);
        return 31 + $clog2(max_block);
    endfunction

    function automatic int rt_w(input int max_block);
        return (sq_w(max_block) + 1) / 2;
    endfunction

    function automatic int cnt_w(input int max_block);
        return $clog2(max_block + 1);
    endfunction

endpackage

FILE: hw/rtl/rbrs_accum.sv
module rbrs_accum #(
    parameter int MAX_BLOCK = rbrs_pkg::MAX_BLOCK_DEF
) (
    input  logic                                        i_clk,
    input  logic                                        i_rst_n,
    input  logic                                        i_load,
    input  logic signed [rbrs_pkg::SMP_W-1:0]           i_sample,
    input  logic                                        i_add,
    input  logic                                        i_clr,
    output logic [rbrs_pkg::cnt_w(MAX_BLOCK)-1:0]       o_count,
    output logic signed [rbrs_pkg::SMP_W+$clog2(MAX_BLOCK)-1:0] o_sum,
    output logic [rbrs_pkg::sq_w(MAX_BLOCK)-1:0]        o_sumsq
);

    localparam int CNT_W = rbrs_pkg::cnt_w(MAX_BLOCK);
    localparam int SUM_W = rbrs_pkg::SMP_W + $clog2(MAX_BLOCK);
    localparam int SQ_W  = rbrs_pkg::sq_w(MAX_BLOCK);

    logic signed [rbrs_pkg::SMP_W-1:0]   r_smp;
    logic [CNT_W-1:0]                    r_count;
    logic signed [SUM_W-1:0]             r_sum;
    logic [SQ_W-1:0]                     r_sumsq;
    logic signed [2*rbrs_pkg::SMP_W-1:0] prod;

    assign prod = r_smp * r_smp;

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_smp <= i_sample;
        end
        if (!i_rst_n || i_clr) begin
            r_count <= '0;
            r_sum   <= '0;
            r_sumsq <= '0;
        end else if (i_add) begin
            r_count <= r_count + CNT_W'(1);
            r_sum   <= r_sum + SUM_W'(r_smp);
            r_sumsq <= r_sumsq + SQ_W'($unsigned(prod));
        end
    end

    assign o_count = r_count;
    assign o_sum   = r_sum;
    assign o_sumsq = r_sumsq;

endmodule

FILE: hw/rtl/rbrs_isu.sv
module rbrs_isu #(
    parameter int MAX_BLOCK = rbrs_pkg::MAX_BLOCK_DEF
) (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  logic                                    i_start,
    input  logic [rbrs_pkg::sq_w(MAX_BLOCK)-1:0]    i_dividend,
    input  logic [rbrs_pkg::cnt_w(MAX_BLOCK)-1:0]   i_divisor,
    output logic                                    o_done,
    output logic [rbrs_pkg::rt_w(MAX_BLOCK)-1:0]    o_root
);

    localparam int SQ_W  = rbrs_pkg::sq_w(MAX_BLOCK);
    localparam int RT_W  = rbrs_pkg::rt_w(MAX_BLOCK);
    localparam int CNT_W = rbrs_pkg::cnt_w(MAX_BLOCK);
    localparam int XW    = 2 * RT_W;
    localparam int U_W   = RT_W + 3;
    localparam int STP_W = $clog2(SQ_W);

    typedef enum logic [1:0] {S_IDLE, S_DIV, S_SQRT} t_state;

    t_state           r_state;
    logic [STP_W-1:0] r_step;
    logic [XW-1:0]    r_x;
    logic [U_W-1:0]   r_rem;
    logic [RT_W-1:0]  r_root;
    logic [CNT_W-1:0] r_div;
    logic             r_done;

    logic [U_W-1:0]   sub_a;
    logic [U_W-1:0]   sub_b;
    logic [U_W:0]     diff;
    logic             ge;

    // shared subtractor: restoring divide, then restoring square root
    always_comb begin
        if (r_state == S_DIV) begin
            sub_a = U_W'({r_rem[CNT_W-1:0], r_x[SQ_W-1]});
            sub_b = U_W'(r_div);
        end else begin
            sub_a = {r_rem[U_W-3:0], r_x[XW-1 -: 2]};
            sub_b = U_W'({r_root, 2'b01});
        end
        diff = {1'b0, sub_a} - {1'b0, sub_b};
        ge   = !diff[U_W];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_done  <= 1'b0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (i_start) begin
                        r_x     <= XW'(i_dividend);
                        r_div   <= i_divisor;
                        r_rem   <= '0;
                        r_root  <= '0;
                        r_step  <= STP_W'(SQ_W - 1);
                        r_done  <= 1'b0;
                        r_state <= S_DIV;
                    end
                end
                S_DIV: begin
                    r_x[SQ_W-1:0] <= {r_x[SQ_W-2:0], ge};
                    if (r_step == '0) begin
                        r_rem   <= '0;
                        r_step  <= STP_W'(RT_W - 1);
                        r_state <= S_SQRT;
                    end else begin
                        r_rem  <= ge ? diff[U_W-1:0] : sub_a;
                        r_step <= r_step - STP_W'(1);
                    end
                end
                S_SQRT: begin
                    r_rem  <= ge ? diff[U_W-1:0] : sub_a;
                    r_root <= {r_root[RT_W-2:0], ge};
                    r_x    <= r_x << 2;
                    if (r_step == '0) begin
                        r_done  <= 1'b1;
                        r_state <= S_IDLE;
                    end else begin
                        r_step <= r_step - STP_W'(1);
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_done = r_done;
    assign o_root = r_root;

endmodule

FILE: hw/rtl/rbrs_emit.sv
module rbrs_emit #(
    parameter int MAX_BLOCK = rbrs_pkg::MAX_BLOCK_DEF
) (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  logic                                    i_load,
    input  logic signed [rbrs_pkg::PV_W-1:0]        i_value,
    input  logic [rbrs_pkg::cnt_w(MAX_BLOCK)-1:0]   i_count,
    input  logic                                    i_tready,
    output logic                                    o_busy,
    output logic                                    o_tvalid,
    output logic [rbrs_pkg::PV_W-1:0]               o_tdata,
    output logic                                    o_tlast
);

    localparam int CNT_W = rbrs_pkg::cnt_w(MAX_BLOCK);

    logic [CNT_W-1:0]              r_left;
    logic [rbrs_pkg::PV_W-1:0]     r_val;

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_val <= i_value;
        end
        if (!i_rst_n) begin
            r_left <= '0;
        end else if (i_load) begin
            r_left <= i_count;
        end else if (o_tvalid && i_tready) begin
            r_left <= r_left - CNT_W'(1);
        end
    end

    assign o_busy   = (r_left != '0);
    assign o_tvalid = o_busy;
    assign o_tdata  = r_val;
    assign o_tlast  = (r_left == CNT_W'(1));

endmodule

FILE: hw/rtl/residual_block_rms_spike.sv
// Residual block RMS spike generator.
// Slave stream: one word per residual sample, tdata = sample, tlast = 1 on
// the last sample before a pitch mark. Master stream: one word per sample of
// a closed block, tdata = signed block RMS (saturated), tlast on the final
// word of the block. A block closes at block_len samples or on tlast.
// Config channel: cfg_data[6:0] = block_len (0 acts as 1, above MAX_BLOCK
// acts as MAX_BLOCK); always ready, write only while the block is idle.
// Flow: a sample that does not close its block goes through the add state
// only. A closing sample also runs the shared subtract unit: a start state,
// a restoring divide of the sum of squares by the sample count, then a
// restoring square root; the first result word is loaded once it is done.
// Results then leave one word per cycle, while the receiver is ready, from
// a register stage; new samples are taken while they drain, but the next
// block result waits until the previous block has been fully taken.
// Reset clears the open block and sets block_len to 8. A stalled receiver
// holds the current word and, once the next block closes, holds the input.
module residual_block_rms_spike #(
    parameter int MAX_BLOCK = rbrs_pkg::MAX_BLOCK_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_s_axis_tvalid,
    output logic                               o_s_axis_tready,
    input  logic [rbrs_pkg::SMP_W-1:0]         i_s_axis_tdata,  // [15:0] sample
    input  logic                               i_s_axis_tlast,  // seg_end
    output logic                               o_m_axis_tvalid,
    input  logic                               i_m_axis_tready,
    output logic [rbrs_pkg::PV_W-1:0]          o_m_axis_tdata,  // [15:0] pulse_value
    output logic                               o_m_axis_tlast,  // last
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [rbrs_pkg::BLEN_W-1:0]        i_cfg_data       // block_len
);

    localparam int CNT_W = rbrs_pkg::cnt_w(MAX_BLOCK);
    localparam int SUM_W = rbrs_pkg::SMP_W + $clog2(MAX_BLOCK);
    localparam int SQ_W  = rbrs_pkg::sq_w(MAX_BLOCK);
    localparam int RT_W  = rbrs_pkg::rt_w(MAX_BLOCK);

    typedef enum logic [1:0] {S_IDLE, S_ADD, S_START, S_CALC} t_state;

    t_state                          r_state;
    logic                            r_seg;
    logic [rbrs_pkg::BLEN_W-1:0]     r_blen;

    logic                            s_acc;
    logic                            add;
    logic                            start;
    logic                            load;
    logic                            close;
    logic [CNT_W-1:0]                lim;
    logic [CNT_W-1:0]                count;
    logic signed [SUM_W-1:0]         sum;
    logic [SQ_W-1:0]                 sumsq;
    logic                            isu_done;
    logic [RT_W-1:0]                 root;
    logic [RT_W-1:0]                 neg_root;
    logic signed [rbrs_pkg::PV_W-1:0] value;
    logic                            emit_busy;

    assign o_cfg_ready     = 1'b1;
    assign o_s_axis_tready = (r_state == S_IDLE);
    assign s_acc           = i_s_axis_tvalid && o_s_axis_tready;

    always_comb begin
        if (r_blen == '0) begin
            lim = CNT_W'(1);
        end else if (r_blen > rbrs_pkg::BLEN_W'(MAX_BLOCK)) begin
            lim = CNT_W'(MAX_BLOCK);
        end else begin
            lim = CNT_W'(r_blen);
        end
    end

    assign close = ((CNT_W+1)'(count) + (CNT_W+1)'(1) >= (CNT_W+1)'(lim)) || r_seg;
    assign add   = (r_state == S_ADD);
    assign start = (r_state == S_START);
    assign load  = (r_state == S_CALC) && isu_done && !emit_busy;

    // sign of the sum, magnitude clamped to the 16-bit range
    assign neg_root = RT_W'(0) - root;
    always_comb begin
        if (sum == '0) begin
            value = '0;
        end else if (!sum[SUM_W-1]) begin
            value = (root > RT_W'(rbrs_pkg::PV_MAX)) ? rbrs_pkg::PV_MAX
                                                     : rbrs_pkg::PV_W'(root);
        end else begin
            value = (root > RT_W'(32768)) ? rbrs_pkg::PV_MIN
                                          : rbrs_pkg::PV_W'(neg_root);
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_acc) begin
            r_seg <= i_s_axis_tlast;
        end
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_blen  <= rbrs_pkg::BLEN_RST;
        end else begin
            if (i_cfg_valid) begin
                r_blen <= i_cfg_data;
            end
            unique case (r_state)
                S_IDLE:  if (s_acc) r_state <= S_ADD;
                S_ADD:   r_state <= close ? S_START : S_IDLE;
                S_START: r_state <= S_CALC;
                S_CALC:  if (load) r_state <= S_IDLE;
                default: r_state <= S_IDLE;
            endcase
        end
    end

    rbrs_accum #(.MAX_BLOCK(MAX_BLOCK)) u_accum (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (s_acc),
        .i_sample (i_s_axis_tdata),
        .i_add    (add),
        .i_clr    (load),
        .o_count  (count),
        .o_sum    (sum),
        .o_sumsq  (sumsq)
    );

    rbrs_isu #(.MAX_BLOCK(MAX_BLOCK)) u_isu (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (start),
        .i_dividend (sumsq),
        .i_divisor  (count),
        .o_done     (isu_done),
        .o_root     (root)
    );

    rbrs_emit #(.MAX_BLOCK(MAX_BLOCK)) u_emit (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (load),
        .i_value  (value),
        .i_count  (count),
        .i_tready (i_m_axis_tready),
        .o_busy   (emit_busy),
        .o_tvalid (o_m_axis_tvalid),
        .o_tdata  (o_m_axis_tdata),
        .o_tlast  (o_m_axis_tlast)
    );

endmodule
